@@ rtl/fsf_pkg.sv @@
// Shared types and constants for the FIR sample filter.
// No dependencies; every other file of the filter but fsf_ram imports this package.
`default_nettype none

package fsf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 15;
	localparam int TAPS_W    = 7;
	localparam int INDEX_W   = 6;

	// Codes of the kind field of an input word.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEF   = 1'b1;

	// Sequencer to multiply-accumulate datapath.
	typedef struct packed {
		logic clr;    // clear the accumulator for a new output
		logic issue;  // a tap read was issued to both memories this cycle
	} mac_ctrl_t;

	// Datapath back to sequencer.
	typedef struct packed {
		logic busy;   // products still in flight toward the accumulator
	} mac_stat_t;

endpackage

`default_nettype wire

@@ rtl/fsf_if.sv @@
// Valid/ready channel interfaces of the FIR sample filter (input and result).
// Depends on fsf_pkg for field widths.
`default_nettype none

interface fsf_in_if import fsf_pkg::*; #(
	parameter int COEF_WIDTH = 18
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [SAMPLE_W-1:0]   sample;
	logic        [INDEX_W-1:0]    coef_index;
	logic signed [COEF_WIDTH-1:0] coef_value;

	modport source (output valid, kind, sample, coef_index, coef_value, input ready);
	modport sink   (input valid, kind, sample, coef_index, coef_value, output ready);
endinterface

interface fsf_out_if import fsf_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;

	modport source (output valid, out_sample, input ready);
	modport sink   (input valid, out_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/fsf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/fsf_mac.sv @@
// Multiply-accumulate datapath: RAM read data, product register, accumulator.
// Depends on fsf_pkg for the control and status structs.
`default_nettype none

module fsf_mac import fsf_pkg::*; #(
	parameter int COEF_WIDTH = 18,
	parameter int ACC_W      = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mac_ctrl_t                    ctrl,
	input  wire logic signed [SAMPLE_W-1:0]   hist_rdata,
	input  wire logic signed [COEF_WIDTH-1:0] coef_rdata,
	output mac_stat_t                         stat,
	output logic signed [ACC_W-1:0]           acc_q
);

	localparam int PW = SAMPLE_W + COEF_WIDTH;

	logic                 vld_s1;
	logic                 vld_s2;
	logic signed [PW-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Memory data is valid in the cycle after the read was issued.
	always_ff @(posedge clk) begin
		prod_s2 <= hist_rdata * coef_rdata;
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign stat.busy = vld_s1 | vld_s2;

endmodule

`default_nettype wire

@@ rtl/fsf_seq.sv @@
// Sequencer of the FIR sample filter: tap count register, delay-line pointer,
// fill count and the tap read loop. Depends on fsf_pkg.
`default_nettype none

module fsf_seq import fsf_pkg::*; #(
	parameter int MAX_TAPS = 64,
	parameter int AW       = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              taps_we,
	input  wire logic [TAPS_W-1:0] taps_wdata,
	input  wire logic              in_valid,
	input  wire logic              in_kind,
	input  wire logic [INDEX_W-1:0] in_coef_index,
	output logic                   in_ready,
	output logic                   hist_we,
	output logic [AW-1:0]          hist_waddr,
	output logic [AW-1:0]          hist_raddr,
	output logic                   coef_we,
	output logic [AW-1:0]          coef_waddr,
	output logic [AW-1:0]          coef_raddr,
	output mac_ctrl_t              mac_ctrl,
	input  wire mac_stat_t         mac_stat,
	input  wire logic              out_free,
	output logic                   out_load
);

	localparam int CW = $clog2(MAX_TAPS + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [TAPS_W-1:0] taps_q;
	logic [AW-1:0]     newest_q;
	logic [CW-1:0]     fill_q;
	logic [AW-1:0]     rptr_q;
	logic [AW-1:0]     tap_q;
	logic [CW-1:0]     rem_q;

	logic              accept;
	logic              take_sample;
	logic [AW-1:0]     newest_nxt;
	logic [CW-1:0]     fill_nxt;
	logic [CW-1:0]     taps_sat;
	logic [CW-1:0]     n_taps;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid & in_ready;
	assign take_sample = accept & (in_kind == KIND_SAMPLE);

	assign newest_nxt = (newest_q == AW'(MAX_TAPS - 1)) ? '0 : newest_q + 1'b1;
	assign fill_nxt   = (fill_q == CW'(MAX_TAPS)) ? fill_q : fill_q + 1'b1;
	assign taps_sat   = (32'(taps_q) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(taps_q);
	// Taps beyond the samples received so far would read delay-line entries that hold no sample.
	assign n_taps     = (taps_sat < fill_nxt) ? taps_sat : fill_nxt;

	assign hist_we    = take_sample;
	assign hist_waddr = newest_nxt;
	assign coef_we    = accept & (in_kind == KIND_COEF) &
	                    (32'(in_coef_index) < 32'(MAX_TAPS));
	assign coef_waddr = AW'(in_coef_index);
	assign hist_raddr = rptr_q;
	assign coef_raddr = tap_q;

	assign mac_ctrl.clr   = take_sample;
	assign mac_ctrl.issue = (state_q == S_RUN);
	assign out_load       = (state_q == S_DONE) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			taps_q   <= TAPS_W'(1);
			newest_q <= '0;
			fill_q   <= '0;
			rptr_q   <= '0;
			tap_q    <= '0;
			rem_q    <= '0;
		end else begin
			if (taps_we) begin
				taps_q <= taps_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take_sample) begin
						newest_q <= newest_nxt;
						fill_q   <= fill_nxt;
						rptr_q   <= newest_nxt;
						tap_q    <= '0;
						rem_q    <= n_taps;
						state_q  <= (n_taps == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					rptr_q <= (rptr_q == '0) ? AW'(MAX_TAPS - 1) : rptr_q - 1'b1;
					tap_q  <= tap_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
					if (rem_q == CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!mac_stat.busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/fir_sample_filter_top.sv @@
// Top level of the direct-form FIR sample filter.
// Depends on fsf_pkg, fsf_if, fsf_ram, fsf_seq and fsf_mac.
`default_nettype none

// Channel   Direction  Handshake      Word carried
// in_ch     sink       valid/ready    kind, sample, coef_index, coef_value
// out_ch    source     valid/ready    out_sample
// taps_*    sink       write enable   taps_in_use (7 bits), no read-back
//
// A coefficient word is written into the coefficient RAM at the edge that accepts
// it, if its index is below MAX_TAPS. A sample word is handled in steps, N being
// the taps in use limited by the samples seen so far: a write to the delay line,
// N reads from the two RAMs, which share one multiply-accumulate unit, a drain of
// the read and product registers, and a load of the result. When N is zero the
// reads and the drain are skipped and a sample word is only accepted and loaded.
// Reset clears the control state and the delay-line fill count, so no clearing
// pass is needed. A stalled result holds in the output register; the next word
// is taken as soon as that result has been loaded into it.

module fir_sample_filter_top import fsf_pkg::*; #(
	parameter int MAX_TAPS   = 64,
	parameter int COEF_WIDTH = 18
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              taps_we,
	input  wire logic [TAPS_W-1:0] taps_wdata,
	fsf_in_if.sink                 in_ch,
	fsf_out_if.source              out_ch
);

	localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int ACC_RAW = SAMPLE_W + COEF_WIDTH + $clog2(MAX_TAPS) + 1;
	// The result takes bits up to FRAC_BITS + SAMPLE_W - 1 of the biased sum.
	localparam int ACC_W   = (ACC_RAW > FRAC_BITS + SAMPLE_W) ? ACC_RAW
	                                                         : FRAC_BITS + SAMPLE_W;

	logic                         hist_we;
	logic [AW-1:0]                hist_waddr;
	logic [AW-1:0]                hist_raddr;
	logic signed [SAMPLE_W-1:0]   hist_rdata;
	logic                         coef_we;
	logic [AW-1:0]                coef_waddr;
	logic [AW-1:0]                coef_raddr;
	logic signed [COEF_WIDTH-1:0] coef_rdata;
	mac_ctrl_t                    mac_ctrl;
	mac_stat_t                    mac_stat;
	logic signed [ACC_W-1:0]      acc;
	logic signed [ACC_W-1:0]      acc_biased;
	logic                         out_free;
	logic                         out_load;
	logic                         out_valid_q;
	logic signed [SAMPLE_W-1:0]   out_sample_q;

	fsf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_TAPS),
		.AW    (AW)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (in_ch.sample),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	fsf_ram #(
		.WIDTH (COEF_WIDTH),
		.DEPTH (MAX_TAPS),
		.AW    (AW)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_ch.coef_value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	fsf_seq #(
		.MAX_TAPS (MAX_TAPS),
		.AW       (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.taps_we       (taps_we),
		.taps_wdata    (taps_wdata),
		.in_valid      (in_ch.valid),
		.in_kind       (in_ch.kind),
		.in_coef_index (in_ch.coef_index),
		.in_ready      (in_ch.ready),
		.hist_we       (hist_we),
		.hist_waddr    (hist_waddr),
		.hist_raddr    (hist_raddr),
		.coef_we       (coef_we),
		.coef_waddr    (coef_waddr),
		.coef_raddr    (coef_raddr),
		.mac_ctrl      (mac_ctrl),
		.mac_stat      (mac_stat),
		.out_free      (out_free),
		.out_load      (out_load)
	);

	fsf_mac #(
		.COEF_WIDTH (COEF_WIDTH),
		.ACC_W      (ACC_W)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mac_ctrl),
		.hist_rdata (hist_rdata),
		.coef_rdata (coef_rdata),
		.stat       (mac_stat),
		.acc_q      (acc)
	);

	// Division by 2^15 truncating toward zero: negative sums get a bias of
	// 2^15 - 1 before the arithmetic shift. The low 16 bits of the quotient wrap.
	assign acc_biased = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= acc_biased[FRAC_BITS +: SAMPLE_W];
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_sample = out_sample_q;

endmodule

`default_nettype wire
